// ===== design/slew_limited_reload_calibrator_defines.svh =====
// ----------------------------------------------------------------------------
// slew limited reload calibrator assertion macros
// concurrent assertion helpers used by slew_limited_reload_calibrator.sv, compiled out with
// ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef SLEW_LIMITED_RELOAD_CALIBRATOR_DEFINES_SVH
`define SLEW_LIMITED_RELOAD_CALIBRATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// property checked at every clock edge outside reset
`define SLRC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequent checked in the cycle after the antecedent
`define SLRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SLRC_ASSERT(label, clk, rst, prop, msg)
`define SLRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== design/slrc_pkg.sv =====
// ----------------------------------------------------------------------------
// slrc_pkg
// shared widths and constants of the slew limited reload calibrator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slrc_pkg;

   localparam int unsigned FIELD_W    = 16;
   localparam int unsigned DIVIDEND_W = 32;
   localparam int unsigned PERIOD_W   = 17;
   localparam int unsigned STEP_CNT_W = $clog2(DIVIDEND_W);

   // reference period in microseconds
   localparam logic [PERIOD_W-1:0] PERIOD_USEC = 17'd125000;

endpackage

`default_nettype wire

// ===== design/slew_limited_reload_calibrator.sv =====
// an accepted word is registered in the idle state, the multiply state starts the
//    divider, the divide state waits through its 32 single-bit steps and registered done,
//    and the write state stores the result word; a zero elapsed time skips the divider
// req_stall is high from acceptance until the result is written, so no new word is taken
//    before the last one is through; a stalled output register holds the write state
// reset: synchronous, clears the sequencer and output valid, reload to INITIAL_RELOAD
// ----------------------------------------------------------------------------
// slew_limited_reload_calibrator
// computes the ideal 125 ms reload from one calibration measurement and moves
// the stored reload one step toward it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "slew_limited_reload_calibrator_defines.svh"

module slew_limited_reload_calibrator #(
   parameter logic [15:0] INITIAL_RELOAD = 16'd3874
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // measurement words
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [slrc_pkg::FIELD_W-1:0]      req_elapsed_usec,
   input  wire logic [slrc_pkg::FIELD_W-1:0]      req_measured_ticks,
   // result words
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [slrc_pkg::FIELD_W-1:0]           rsp_reload_value,
   output logic [slrc_pkg::FIELD_W-1:0]           rsp_target_reload,
   output logic                                   rsp_zero_interval
);

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MULT   = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_WRITE  = 4'b1000
   } state_type;

   localparam int unsigned PROD_W = slrc_pkg::PERIOD_W + slrc_pkg::FIELD_W;

   state_type                             state_ff, state_in;
   logic [slrc_pkg::FIELD_W-1:0]          elapsed_ff, elapsed_in;
   logic [slrc_pkg::FIELD_W-1:0]          ticks_ff, ticks_in;
   logic                                  zero_ff, zero_in;
   logic [slrc_pkg::FIELD_W-1:0]          reload_ff, reload_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [slrc_pkg::FIELD_W-1:0]          rsp_reload_ff, rsp_reload_in;
   logic [slrc_pkg::FIELD_W-1:0]          rsp_target_ff, rsp_target_in;
   logic                                  rsp_zero_ff, rsp_zero_in;

   logic                                  req_take;
   logic                                  out_free;
   logic [PROD_W-1:0]                     product_full;
   logic                                  div_start;
   logic                                  div_done;
   logic [slrc_pkg::FIELD_W-1:0]          div_quotient;
   logic [slrc_pkg::FIELD_W-1:0]          target;

   // input is taken only while the sequencer is idle
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // 125000 * ticks, kept modulo 2^32 when handed to the divider
   assign product_full = {{slrc_pkg::FIELD_W{1'b0}}, slrc_pkg::PERIOD_USEC}
                       * {{slrc_pkg::PERIOD_W{1'b0}}, ticks_ff};

   assign div_start = (state_ff == ST_MULT);

   slrc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product_full[slrc_pkg::DIVIDEND_W-1:0]),
      .divisor  (elapsed_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // low 16 bits of the quotient minus one, wrapping; zero interval gives 0
   assign target = zero_ff ? '0 : (div_quotient - 1'b1);

   always_comb begin
      state_in      = state_ff;
      elapsed_in    = elapsed_ff;
      ticks_in      = ticks_ff;
      zero_in       = zero_ff;
      reload_in     = reload_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_reload_in = rsp_reload_ff;
      rsp_target_in = rsp_target_ff;
      rsp_zero_in   = rsp_zero_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               elapsed_in = req_elapsed_usec;
               ticks_in   = req_measured_ticks;
               zero_in    = (req_elapsed_usec == '0);
               // no division for a zero interval
               state_in   = (req_elapsed_usec == '0) ? ST_WRITE : ST_MULT;
            end
         end
         ST_MULT: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               // single step toward the target, held on a zero interval
               if (!zero_ff && (target < reload_ff)) begin
                  reload_in = reload_ff - 1'b1;
               end else if (!zero_ff && (target > reload_ff)) begin
                  reload_in = reload_ff + 1'b1;
               end
               rsp_valid_in  = 1'b1;
               rsp_reload_in = reload_in;
               rsp_target_in = target;
               rsp_zero_in   = zero_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         reload_ff    <= INITIAL_RELOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         reload_ff    <= reload_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      elapsed_ff    <= elapsed_in;
      ticks_ff      <= ticks_in;
      zero_ff       <= zero_in;
      rsp_reload_ff <= rsp_reload_in;
      rsp_target_ff <= rsp_target_in;
      rsp_zero_ff   <= rsp_zero_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reload_value  = rsp_reload_ff;
   assign rsp_target_reload = rsp_target_ff;
   assign rsp_zero_interval = rsp_zero_ff;

   // accepted word always starts the multiply or, for zero time, the write
   `SLRC_ASSERT_NEXT(a_take_start, clock, reset, req_take, (state_ff == ST_MULT) || (state_ff == ST_WRITE), "accepted word did not start the sequencer")
   // divider finishes only while the sequencer waits for it
   `SLRC_ASSERT(a_done_in_divide, clock, reset, !div_done || (state_ff == ST_DIVIDE), "divider done outside the divide state")
   // reload changes only when a result is written
   `SLRC_ASSERT_NEXT(a_reload_hold, clock, reset, state_ff != ST_WRITE, $stable(reload_ff), "reload changed outside the write state")
   // reload moves at most one count per word
   `SLRC_ASSERT(a_reload_step, clock, reset, (reload_ff == $past(reload_ff)) || (reload_ff == 16'($past(reload_ff) + 16'd1)) || (reload_ff == 16'($past(reload_ff) - 16'd1)), "reload moved by more than one step")

endmodule

`default_nettype wire

// ===== design/slrc_div.sv =====
// ----------------------------------------------------------------------------
// slrc_div
// radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one
// quotient bit per cycle while busy
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slrc_div (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [slrc_pkg::DIVIDEND_W-1:0]       dividend,
   input  wire logic [slrc_pkg::FIELD_W-1:0]          divisor,
   output logic                                       done,
   output logic [slrc_pkg::FIELD_W-1:0]               quotient
);

   logic                                  busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic [slrc_pkg::STEP_CNT_W-1:0]       count_ff, count_in;
   logic [slrc_pkg::FIELD_W-1:0]          rem_ff, rem_in;
   logic [slrc_pkg::DIVIDEND_W-1:0]       work_ff, work_in;
   logic [slrc_pkg::FIELD_W-1:0]          divisor_ff, divisor_in;

   logic [slrc_pkg::FIELD_W:0]            trial;
   logic [slrc_pkg::FIELD_W:0]            diff;
   logic                                  ge;

   // partial remainder with the next dividend bit brought down
   assign trial = {rem_ff, work_ff[slrc_pkg::DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign ge    = (trial >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      work_in    = work_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         work_in    = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in   = ge ? diff[slrc_pkg::FIELD_W-1:0] : trial[slrc_pkg::FIELD_W-1:0];
         work_in  = {work_ff[slrc_pkg::DIVIDEND_W-2:0], ge};
         count_in = count_ff + 1'b1;
         if (count_ff == slrc_pkg::STEP_CNT_W'(slrc_pkg::DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      work_ff    <= work_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = work_ff[slrc_pkg::FIELD_W-1:0];

endmodule

`default_nettype wire
